// ===== src/tdc_time_of_flight_calc_defines.svh =====
// assertion helpers shared by the checker
`ifndef TDC_TIME_OF_FLIGHT_CALC_DEFINES_SVH
`define TDC_TIME_OF_FLIGHT_CALC_DEFINES_SVH

// clocked assertion, quiet while reset is applied
`define TDC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tdc check failed");

// clocked assertion that also holds during reset
`define TDC_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("tdc check failed");

`endif

// ===== src/tdc_pkg.sv =====
package tdc_pkg;

    // register indexes on the configuration port
    localparam logic [2:0] REG_CLOCK_PERIOD = 3'd0;
    localparam logic [2:0] REG_CAL_PERIODS  = 3'd1;
    localparam logic [2:0] REG_FUDGE        = 3'd2;
    localparam logic [2:0] REG_DILATION     = 3'd3;
    localparam logic [2:0] REG_FORCED_STOP  = 3'd4;

    localparam logic [19:0] CLOCK_PERIOD_RST = 20'd100000;
    localparam logic [5:0]  CAL_PERIODS_RST  = 6'd20;

    localparam longint SCALE_ONE = 64'd1000000;
    localparam logic [26:0] TOF_MIN = 27'd300000;
    localparam logic [26:0] TOF_MAX = 27'd100300000;
    localparam logic [64:0] RING_SAT = 65'h0_4000_0000_0000_0000;

    // dividend and divisor widths of the two divider chains
    localparam int CAL_NW  = 44;
    localparam int CAL_DW  = 6;
    localparam int RING_NW = 65;
    localparam int RING_DW = 44;

endpackage

// ===== src/tdc_div_cell.sv =====
module tdc_div_cell #(
    parameter int NW = 8,
    parameter int DW = 4,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] in_rem,
    input  logic [NW-1:0] in_num,
    input  logic [DW-1:0] in_div,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [DW-1:0] out_rem,
    output logic [NW-1:0] out_num,
    output logic [DW-1:0] out_div,
    output logic [SW-1:0] out_side
);

    logic          valid_reg;
    logic [DW-1:0] rem_reg, rem_next, div_reg;
    logic [NW-1:0] num_reg, num_next;
    logic [SW-1:0] side_reg;
    logic [DW:0]   trial, diff;
    logic          ge;

    // one restoring step: shift in next dividend bit, subtract if it fits
    always_comb
    begin
        trial    = {in_rem, in_num[NW-1]};
        diff     = trial - {1'b0, in_div};
        ge       = (trial >= {1'b0, in_div});
        rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
        num_next = {in_num[NW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            num_reg  <= num_next;
            div_reg  <= in_div;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_num   = num_reg;
    assign out_div   = div_reg;
    assign out_side  = side_reg;

endmodule

// ===== src/tdc_div_chain.sv =====
module tdc_div_chain #(
    parameter int NW = 8,
    parameter int DW = 4,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] in_num,
    input  logic [DW-1:0] in_div,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [NW-1:0] out_quo,
    output logic [SW-1:0] out_side
);

    logic          valid_w [0:NW];
    logic [DW-1:0] rem_w   [0:NW];
    logic [NW-1:0] num_w   [0:NW];
    logic [DW-1:0] div_w   [0:NW];
    logic [SW-1:0] side_w  [0:NW];

    assign valid_w[0] = in_valid;
    assign rem_w[0]   = '0;
    assign num_w[0]   = in_num;
    assign div_w[0]   = in_div;
    assign side_w[0]  = in_side;

    // row of cells, one quotient bit per cell
    for (genvar i = 0; i < NW; i++)
    begin : g_cell
        tdc_div_cell #(.NW(NW), .DW(DW), .SW(SW)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_valid (valid_w[i]),
            .in_rem   (rem_w[i]),
            .in_num   (num_w[i]),
            .in_div   (div_w[i]),
            .in_side  (side_w[i]),
            .out_valid(valid_w[i+1]),
            .out_rem  (rem_w[i+1]),
            .out_num  (num_w[i+1]),
            .out_div  (div_w[i+1]),
            .out_side (side_w[i+1])
        );
    end

    assign out_valid = valid_w[NW];
    assign out_quo   = num_w[NW];
    assign out_side  = side_w[NW];

endmodule

// ===== src/tdc_time_of_flight_calc.sv =====
// pipeline from accepted input to result valid, mostly divider cells (4 front stages,
//   44-cell calibration divider, 1 stage, 65-cell ring divider, 2 stages)
// throughput: one transaction per cycle unless a held result stalls the pipeline
// a stalled result freezes the whole pipeline until it is taken
// reset: asynchronous active low, clears all valid bits and loads register defaults
module tdc_time_of_flight_calc (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [23:0] start_ring_count,
    input  logic [23:0] stop_ring_count,
    input  logic [23:0] coarse_ticks,
    input  logic [23:0] cal_one,
    input  logic [23:0] cal_many,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [26:0] tof_ps
);
    import tdc_pkg::*;

    localparam int CAL_SW  = 64 + 1 + 44 + 1;
    localparam int RING_SW = 1 + 44;

    logic [19:0] clock_period_reg;
    logic [5:0]  cal_periods_reg;
    logic [20:0] fudge_reg;
    logic [19:0] dilation_reg;
    logic [23:0] forced_stop_reg;

    logic en;
    logic [2:0] reg_idx;

    // configuration writes
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_period_reg <= CLOCK_PERIOD_RST;
            cal_periods_reg  <= CAL_PERIODS_RST;
            fudge_reg        <= '0;
            dilation_reg     <= '0;
            forced_stop_reg  <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (reg_idx)
                REG_CLOCK_PERIOD: clock_period_reg <= pwdata[19:0];
                REG_CAL_PERIODS:  cal_periods_reg  <= pwdata[5:0];
                REG_FUDGE:        fudge_reg        <= pwdata[20:0];
                REG_DILATION:     dilation_reg     <= pwdata[19:0];
                REG_FORCED_STOP:  forced_stop_reg  <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (reg_idx)
            REG_CLOCK_PERIOD: prdata = {12'd0, clock_period_reg};
            REG_CAL_PERIODS:  prdata = {26'd0, cal_periods_reg};
            REG_FUDGE:        prdata = {11'd0, fudge_reg};
            REG_DILATION:     prdata = {12'd0, dilation_reg};
            REG_FORCED_STOP:  prdata = {8'd0, forced_stop_reg};
            default:          prdata = '0;
        endcase
    end

    // global advance: everything moves unless the result is held
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    // calibration divisor from the register, never below one
    logic [5:0] denom, half1;
    assign denom = (cal_periods_reg >= 6'd2) ? (cal_periods_reg - 6'd1) : 6'd1;
    assign half1 = denom >> 1;

    // stage 0: differences
    logic               s0_valid_reg;
    logic signed [24:0] s0_dcal_reg, s0_rt_reg;
    logic [23:0]        s0_coarse_reg;
    logic [23:0]        stop_eff;

    assign stop_eff = (forced_stop_reg != 24'd0) ? forced_stop_reg : stop_ring_count;

    // stage 1: products
    logic               s1_valid_reg;
    logic signed [45:0] s1_num_reg;
    logic [23:0]        s1_rtm_reg;
    logic               s1_rtpos_reg;
    logic [43:0]        s1_ccp_reg;
    logic signed [20:0] scale;
    assign scale = 21'sd1000000 - $signed({1'b0, dilation_reg});

    // stage 2: rounding bias and ring ticks times period
    logic               s2_valid_reg;
    logic [43:0]        s2_n1_reg;
    logic               s2_n1pos_reg;
    logic [43:0]        s2_mag44_reg;
    logic               s2_rtpos_reg;
    logic [43:0]        s2_ccp_reg;
    logic signed [45:0] n1;
    assign n1 = s1_num_reg + $signed({40'd0, half1});

    // stage 3: scale by one million
    logic        s3_valid_reg;
    logic [43:0] s3_n1_reg;
    logic        s3_n1pos_reg;
    logic [63:0] s3_mag_reg;
    logic        s3_rtpos_reg;
    logic [43:0] s3_ccp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg <= in_valid;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_dcal_reg   <= $signed({1'b0, cal_many}) - $signed({1'b0, cal_one});
            s0_rt_reg     <= $signed({1'b0, start_ring_count}) - $signed({1'b0, stop_eff});
            s0_coarse_reg <= coarse_ticks;

            s1_num_reg   <= s0_dcal_reg * scale;
            s1_rtm_reg   <= s0_rt_reg[24] ? 24'(-s0_rt_reg) : s0_rt_reg[23:0];
            s1_rtpos_reg <= !s0_rt_reg[24] && (s0_rt_reg != 25'sd0);
            s1_ccp_reg   <= s0_coarse_reg * clock_period_reg;

            s2_n1_reg    <= n1[43:0];
            s2_n1pos_reg <= !n1[45] && (n1 != 46'sd0);
            s2_mag44_reg <= s1_rtm_reg * clock_period_reg;
            s2_rtpos_reg <= s1_rtpos_reg;
            s2_ccp_reg   <= s1_ccp_reg;

            s3_n1_reg    <= s2_n1_reg;
            s3_n1pos_reg <= s2_n1pos_reg;
            s3_mag_reg   <= 64'(s2_mag44_reg * SCALE_ONE);
            s3_rtpos_reg <= s2_rtpos_reg;
            s3_ccp_reg   <= s2_ccp_reg;
        end
    end

    // calibration count divider
    logic              c_valid;
    logic [CAL_NW-1:0] c_quo;
    logic [CAL_SW-1:0] c_side;

    tdc_div_chain #(.NW(CAL_NW), .DW(CAL_DW), .SW(CAL_SW)) u_cal_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s3_valid_reg),
        .in_num   (s3_n1_reg),
        .in_div   (denom),
        .in_side  ({s3_mag_reg, s3_rtpos_reg, s3_ccp_reg, s3_n1pos_reg}),
        .out_valid(c_valid),
        .out_quo  (c_quo),
        .out_side (c_side)
    );

    // stage 4: floor the count, fold sign and rounding into the dividend
    logic [63:0] c_mag;
    logic        c_rtpos, c_n1pos;
    logic [43:0] c_ccp, cal, half2;
    logic [64:0] num2;
    logic        neg2;

    assign {c_mag, c_rtpos, c_ccp, c_n1pos} = c_side;

    always_comb
    begin
        cal   = (!c_n1pos || c_quo == '0) ? 44'd1 : c_quo;
        half2 = cal >> 1;
        neg2  = 1'b0;
        if (c_rtpos)
        begin
            num2 = {1'b0, c_mag} + {21'd0, half2};
        end
        else if (c_mag >= {20'd0, half2})
        begin
            num2 = {1'b0, c_mag} - {21'd0, half2};
            neg2 = 1'b1;
        end
        else
        begin
            num2 = {21'd0, half2} - {1'b0, c_mag};
        end
    end

    logic        s4_valid_reg;
    logic [64:0] s4_num_reg;
    logic [43:0] s4_cal_reg;
    logic        s4_neg_reg;
    logic [43:0] s4_ccp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s4_valid_reg <= c_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_num_reg <= num2;
            s4_cal_reg <= cal;
            s4_neg_reg <= neg2;
            s4_ccp_reg <= c_ccp;
        end
    end

    // ring interpolation divider
    logic               r_valid;
    logic [RING_NW-1:0] r_quo;
    logic [RING_SW-1:0] r_side;

    tdc_div_chain #(.NW(RING_NW), .DW(RING_DW), .SW(RING_SW)) u_ring_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s4_valid_reg),
        .in_num   (s4_num_reg),
        .in_div   (s4_cal_reg),
        .in_side  ({s4_neg_reg, s4_ccp_reg}),
        .out_valid(r_valid),
        .out_quo  (r_quo),
        .out_side (r_side)
    );

    // stage 5: saturate and apply sign
    logic [63:0] ring_mag;
    assign ring_mag = (r_quo > RING_SAT) ? RING_SAT[63:0] : r_quo[63:0];

    logic               s5_valid_reg;
    logic signed [63:0] s5_ring_reg;
    logic [43:0]        s5_ccp_reg;

    // stage 6: sum and clamp into the output register
    logic signed [65:0] tof_sum;
    logic [26:0]        tof_next;
    logic               out_valid_reg;
    logic [26:0]        tof_reg;

    always_comb
    begin
        tof_sum = $signed({22'd0, s5_ccp_reg})
                - $signed({{45{fudge_reg[20]}}, fudge_reg})
                + $signed({{2{s5_ring_reg[63]}}, s5_ring_reg});
        if (tof_sum < $signed({39'd0, TOF_MIN}))
        begin
            tof_next = TOF_MIN;
        end
        else if (tof_sum > $signed({39'd0, TOF_MAX}))
        begin
            tof_next = TOF_MAX;
        end
        else
        begin
            tof_next = tof_sum[26:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s5_valid_reg  <= r_valid;
            out_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_ring_reg <= r_side[44] ? -$signed(ring_mag) : $signed(ring_mag);
            s5_ccp_reg  <= r_side[43:0];
            tof_reg     <= tof_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign tof_ps    = tof_reg;

endmodule

// ===== src/tdc_checker.sv =====
`include "tdc_time_of_flight_calc_defines.svh"

module tdc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [26:0] tof_ps
);
    import tdc_pkg::*;

    // results always sit inside the clamp window
    `TDC_ASSERT(a_tof_range, out_valid |-> (tof_ps >= TOF_MIN && tof_ps <= TOF_MAX))

    // input is held back exactly when a result is held
    `TDC_ASSERT(a_stall_link, in_stall == (out_valid && out_stall))

    // a held result stays put
    `TDC_ASSERT(a_hold, (out_valid && out_stall) |=> (out_valid && $stable(tof_ps)))

    // nothing is pending when reset is released
    `TDC_ASSERT_ALWAYS(a_reset_quiet, $rose(rst_n) |-> !out_valid)

endmodule

bind tdc_time_of_flight_calc tdc_checker u_tdc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .tof_ps   (tof_ps)
);
